@@ src/mct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants for the mouse cursor tracker.
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int COORD_BITS  = 12;
	localparam int LIMIT_BITS  = 12;
	localparam int DELTA_BITS  = 9;
	localparam int BTN_COUNT   = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

	// status byte bit positions
	localparam int ST_X_SIGN = 4;
	localparam int ST_Y_SIGN = 5;

	// register indexes
	localparam logic REG_H_LIMIT = 1'b0;
	localparam logic REG_V_LIMIT = 1'b1;

	localparam logic [LIMIT_BITS-1:0] H_LIMIT_RST = LIMIT_BITS'(1024);
	localparam logic [LIMIT_BITS-1:0] V_LIMIT_RST = LIMIT_BITS'(768);

	// one classified packet
	typedef struct packed {
		logic [BTN_COUNT-1:0]         down;
		logic [BTN_COUNT-1:0]         up;
		logic signed [DELTA_BITS-1:0] dx;
		logic signed [DELTA_BITS-1:0] dy;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ src/mct_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_front
// Accepts packets, sign-extends the movement bytes and finds button edges.
// ----------------------------------------------------------------------------
module mct_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           status_byte,
	input  logic [7:0]           x_move,
	input  logic [7:0]           y_move,
	output logic                 push,
	output mct_pkg::item_t       push_item,
	input  logic                 q_full
);
	import mct_pkg::*;

	logic [BTN_COUNT-1:0] held_q;
	logic [BTN_COUNT-1:0] now;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign now      = status_byte[BTN_COUNT-1:0];

	always_comb begin
		push_item.down = now & ~held_q;
		push_item.up   = held_q & ~now;
		push_item.dx   = $signed({status_byte[ST_X_SIGN], x_move});
		push_item.dy   = $signed({status_byte[ST_Y_SIGN], y_move});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (push) begin
			held_q <= now;
		end
	end

endmodule

@@ src/mct_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module mct_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mct_pkg::item_t       push_item,
	input  logic                 pop,
	output mct_pkg::item_t       head,
	output mct_pkg::q_status_t   status
);
	import mct_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/mct_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_back
// Applies queued moves to the cursor position, clamped at zero and at the
// limit; holds the result word until taken. Also holds the limit registers.
// ----------------------------------------------------------------------------
module mct_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [mct_pkg::LIMIT_BITS-1:0] cfg_data,
	input  logic                          q_empty,
	input  mct_pkg::item_t                head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mct_pkg::COORD_BITS-1:0] cursor_x,
	output logic [mct_pkg::COORD_BITS-1:0] cursor_y,
	output logic [mct_pkg::BTN_COUNT-1:0]  down_edges,
	output logic [mct_pkg::BTN_COUNT-1:0]  up_edges
);
	import mct_pkg::*;

	localparam int SUM_W = COORD_BITS + 2;
	localparam int CMP_W = ((COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS) + 1;

	logic [LIMIT_BITS-1:0] h_limit_q;
	logic [LIMIT_BITS-1:0] v_limit_q;
	logic [COORD_BITS-1:0] pos_x_q;
	logic [COORD_BITS-1:0] pos_y_q;
	logic [BTN_COUNT-1:0]  down_q;
	logic [BTN_COUNT-1:0]  up_q;
	logic                  out_valid_q;

	logic [COORD_BITS-1:0]   hl;
	logic [COORD_BITS-1:0]   vl;
	logic signed [SUM_W-1:0] x_sum;
	logic signed [SUM_W-1:0] y_sum;
	logic [COORD_BITS-1:0]   x_next;
	logic [COORD_BITS-1:0]   y_next;

	// limits past the coordinate range saturate to the largest coordinate
	function automatic logic [COORD_BITS-1:0] eff_limit(input logic [LIMIT_BITS-1:0] lim);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(lim);
		if (ext > CMP_W'(COORD_MAX)) begin
			return COORD_MAX;
		end
		return ext[COORD_BITS-1:0];
	endfunction

	// saturate a signed sum into [0, COORD_MAX]
	function automatic logic [COORD_BITS-1:0] cap(input logic signed [SUM_W-1:0] v);
		if (v < 0) begin
			return '0;
		end
		if (v > $signed({2'b00, COORD_MAX})) begin
			return COORD_MAX;
		end
		return v[COORD_BITS-1:0];
	endfunction

	assign pop       = !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cursor_x  = pos_x_q;
	assign cursor_y  = pos_y_q;
	assign down_edges = down_q;
	assign up_edges   = up_q;

	always_comb begin
		hl    = eff_limit(h_limit_q);
		vl    = eff_limit(v_limit_q);
		x_sum = $signed({2'b00, pos_x_q}) + SUM_W'(head.dx);
		// screen y grows downward
		y_sum = $signed({2'b00, pos_y_q}) - SUM_W'(head.dy);

		if (head.dx[DELTA_BITS-1]) begin
			x_next = cap(x_sum);
		end else if (x_sum > $signed({2'b00, hl})) begin
			x_next = hl;
		end else begin
			x_next = x_sum[COORD_BITS-1:0];
		end

		if (!head.dy[DELTA_BITS-1]) begin
			y_next = cap(y_sum);
		end else if (y_sum > $signed({2'b00, vl})) begin
			y_next = vl;
		end else begin
			y_next = y_sum[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_limit_q <= H_LIMIT_RST;
			v_limit_q <= V_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_H_LIMIT: h_limit_q <= cfg_data;
				REG_V_LIMIT: v_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			pos_x_q     <= x_next;
			pos_y_q     <= y_next;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			down_q <= head.down;
			up_q   <= head.up;
		end
	end

endmodule

@@ src/mouse_cursor_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_cursor_tracker
// Tracks PS/2 mouse button edges and a clamped cursor position.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  input    | in_valid/in_ready, status_byte, x/y_move  | one packet per word
//  output   | out_valid/out_ready, cursor_x/y, edges    | one result per word
//  config   | cfg_we, cfg_index, cfg_data               | h_limit, v_limit
//
//  One word per cycle sustained while out_ready is high; a result passes
//  through the combinational front classify, the two-entry queue's storage
//  and the back's output registers, which take the new position as it pops;
//  out_valid rises once the back has registered it.
//  The back's position accumulator closes its loop through pos_x_q/pos_y_q.
//  Reset clears the position, button state, queue and output valid; limits
//  return to 1024 and 768. Output stalls back up through the queue to in_ready.
// ----------------------------------------------------------------------------
module mouse_cursor_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     status_byte,
	input  logic [7:0]                     x_move,
	input  logic [7:0]                     y_move,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mct_pkg::COORD_BITS-1:0] cursor_x,
	output logic [mct_pkg::COORD_BITS-1:0] cursor_y,
	output logic                           left_down_edge,
	output logic                           left_up_edge,
	output logic                           right_down_edge,
	output logic                           right_up_edge,
	output logic                           middle_down_edge,
	output logic                           middle_up_edge,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [mct_pkg::LIMIT_BITS-1:0] cfg_data
);
	import mct_pkg::*;

	logic                 push;
	logic                 pop;
	item_t                push_item;
	item_t                head;
	q_status_t            q_status;
	logic [BTN_COUNT-1:0] down_edges;
	logic [BTN_COUNT-1:0] up_edges;

	mct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.status_byte (status_byte),
		.x_move      (x_move),
		.y_move      (y_move),
		.push        (push),
		.push_item   (push_item),
		.q_full      (q_status.full)
	);

	mct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	mct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_empty    (q_status.empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor_x   (cursor_x),
		.cursor_y   (cursor_y),
		.down_edges (down_edges),
		.up_edges   (up_edges)
	);

	assign left_down_edge   = down_edges[0];
	assign right_down_edge  = down_edges[1];
	assign middle_down_edge = down_edges[2];
	assign left_up_edge     = up_edges[0];
	assign right_up_edge    = up_edges[1];
	assign middle_up_edge   = up_edges[2];

`ifndef ASSERT_OFF
	a_q_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue both full and empty");

	a_edge_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((down_edges & up_edges) == '0))
		else $error("button edge both down and up");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(cursor_x) && $stable(cursor_y)))
		else $error("position moved while result stalled");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");
`endif

endmodule
